### rtl/core/pl0_pkg.sv
`default_nettype none
package pl0_pkg;

	// Opcodes
	localparam logic [4:0] OP_LIT  = 5'd1;
	localparam logic [4:0] OP_RTN  = 5'd2;
	localparam logic [4:0] OP_LOD  = 5'd3;
	localparam logic [4:0] OP_STO  = 5'd4;
	localparam logic [4:0] OP_CAL  = 5'd5;
	localparam logic [4:0] OP_INC  = 5'd6;
	localparam logic [4:0] OP_JMP  = 5'd7;
	localparam logic [4:0] OP_JPC  = 5'd8;
	localparam logic [4:0] OP_WRT  = 5'd9;
	localparam logic [4:0] OP_RED  = 5'd10;
	localparam logic [4:0] OP_HLT  = 5'd11;
	localparam logic [4:0] OP_NEG  = 5'd12;
	localparam logic [4:0] OP_ADD  = 5'd13;
	localparam logic [4:0] OP_SUB  = 5'd14;
	localparam logic [4:0] OP_MUL  = 5'd15;
	localparam logic [4:0] OP_DIV  = 5'd16;
	localparam logic [4:0] OP_ODD  = 5'd17;
	localparam logic [4:0] OP_MOD  = 5'd18;
	localparam logic [4:0] OP_EQL  = 5'd19;
	localparam logic [4:0] OP_NEQ  = 5'd20;
	localparam logic [4:0] OP_LES  = 5'd21;
	localparam logic [4:0] OP_LEQ  = 5'd22;
	localparam logic [4:0] OP_GTR  = 5'd23;
	localparam logic [4:0] OP_GEQ  = 5'd24;

	// Status codes
	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_HALT  = 3'd1;
	localparam logic [2:0] ST_DIVZ  = 3'd2;
	localparam logic [2:0] ST_BADOP = 3'd3;
	localparam logic [2:0] ST_STACK = 3'd4;

	// Instruction classes from the front end
	typedef enum logic [3:0] {
		CL_LIT, CL_RTN, CL_LOD, CL_STO, CL_CAL, CL_INC, CL_JMP, CL_JPC,
		CL_WRITE, CL_READ, CL_HALT, CL_ALU, CL_DIV, CL_ODD, CL_BAD
	} cls_t;

	// Execute state machine
	typedef enum logic [3:0] {
		BS_IDLE, BS_EXEC, BS_WALK, BS_WALK_RD, BS_LOD_RD, BS_CAL,
		BS_RTN_LINK, BS_RTN_RET, BS_DIV
	} bst_t;

	// One classified instruction in the queue
	typedef struct packed {
		cls_t        cls;
		logic [4:0]  op;
		logic [3:0]  tgt;
		logic [3:0]  src_a;
		logic [3:0]  src_b;
		logic [3:0]  rsel0;
		logic [3:0]  lvl;
		logic        lvl_bad;
		logic [31:0] m;
		logic [31:0] rv;
	} entry_t;

endpackage
`default_nettype wire

### rtl/core/pl0_front.sv
`default_nettype none
module pl0_front #(
	parameter int REG_COUNT  = 16,
	parameter int LEVELS_MAX = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [4:0]         op,
	input  wire logic [3:0]         target_reg,
	input  wire logic [3:0]         l_field,
	input  wire logic signed [31:0] m_field,
	input  wire logic signed [31:0] read_value,
	output pl0_pkg::entry_t         head,
	output logic                    head_vld,
	input  wire logic               pop
);

	pl0_pkg::entry_t ent;
	pl0_pkg::entry_t q_mem [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;

	// Wrap a 4-bit register index into the register count
	function automatic logic [3:0] wrap_reg(input logic [3:0] v);
		logic [4:0] r;
		r = {1'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (r >= 5'(REG_COUNT)) begin
				r = r - 5'(REG_COUNT);
			end
		end
		wrap_reg = r[3:0];
	endfunction

	// Classify the incoming transaction
	always_comb begin
		ent.op      = op;
		ent.tgt     = wrap_reg(target_reg);
		ent.src_a   = wrap_reg(l_field);
		ent.src_b   = wrap_reg(m_field[3:0]);
		ent.lvl     = l_field;
		ent.lvl_bad = (l_field > 4'(LEVELS_MAX));
		ent.m       = m_field;
		ent.rv      = read_value;
		unique case (op) inside
			pl0_pkg::OP_LIT: ent.cls = pl0_pkg::CL_LIT;
			pl0_pkg::OP_RTN: ent.cls = pl0_pkg::CL_RTN;
			pl0_pkg::OP_LOD: ent.cls = pl0_pkg::CL_LOD;
			pl0_pkg::OP_STO: ent.cls = pl0_pkg::CL_STO;
			pl0_pkg::OP_CAL: ent.cls = pl0_pkg::CL_CAL;
			pl0_pkg::OP_INC: ent.cls = pl0_pkg::CL_INC;
			pl0_pkg::OP_JMP: ent.cls = pl0_pkg::CL_JMP;
			pl0_pkg::OP_JPC: ent.cls = pl0_pkg::CL_JPC;
			pl0_pkg::OP_WRT: ent.cls = pl0_pkg::CL_WRITE;
			pl0_pkg::OP_RED: ent.cls = pl0_pkg::CL_READ;
			pl0_pkg::OP_HLT: ent.cls = pl0_pkg::CL_HALT;
			pl0_pkg::OP_ODD: ent.cls = pl0_pkg::CL_ODD;
			pl0_pkg::OP_DIV, pl0_pkg::OP_MOD: ent.cls = pl0_pkg::CL_DIV;
			pl0_pkg::OP_NEG, pl0_pkg::OP_ADD, pl0_pkg::OP_SUB, pl0_pkg::OP_MUL,
			pl0_pkg::OP_EQL, pl0_pkg::OP_NEQ, pl0_pkg::OP_LES, pl0_pkg::OP_LEQ,
			pl0_pkg::OP_GTR, pl0_pkg::OP_GEQ: ent.cls = pl0_pkg::CL_ALU;
			default: ent.cls = pl0_pkg::CL_BAD;
		endcase
		// Port 0 reads the tested register or the first source
		if (ent.cls == pl0_pkg::CL_STO || ent.cls == pl0_pkg::CL_JPC ||
				ent.cls == pl0_pkg::CL_WRITE || ent.cls == pl0_pkg::CL_ODD) begin
			ent.rsel0 = ent.tgt;
		end else begin
			ent.rsel0 = ent.src_a;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign head     = q_mem[rd_ptr_q];
	assign head_vld = (cnt_q != 2'd0);

	// Store queue entries
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= ent;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

### rtl/core/pl0_div.sv
`default_nettype none
module pl0_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient,
	output logic [31:0]      remainder
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic        qneg_q;
	logic        rneg_q;
	logic [32:0] shifted;
	logic        fits;
	logic [32:0] diff;

	// One quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= 32'd0;
			quo_q  <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q  <= divisor[31] ? (32'd0 - divisor) : divisor;
			qneg_q <= dividend[31] ^ divisor[31];
			rneg_q <= dividend[31];
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	// Count iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? (32'd0 - quo_q) : quo_q;
	assign remainder = rneg_q ? (32'd0 - rem_q) : rem_q;

endmodule
`default_nettype wire

### rtl/core/pl0_back.sv
`default_nettype none
module pl0_back #(
	parameter int STACK_DEPTH = 2048,
	parameter int CODE_DEPTH  = 512,
	parameter int REG_COUNT   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [9:0]  cfg_len,
	input  pl0_pkg::entry_t  head,
	input  wire logic        head_vld,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [8:0]       next_pc,
	output logic             write_valid,
	output logic [31:0]      write_value,
	output logic [10:0]      stack_top,
	output logic [10:0]      frame_base
);

	localparam int SW  = $clog2(STACK_DEPTH);
	localparam int PCW = $clog2(CODE_DEPTH + 1);
	localparam int RW  = $clog2(REG_COUNT);
	localparam logic [SW:0]   DEPTH_W  = (SW + 1)'(STACK_DEPTH);
	localparam logic [31:0]   DEPTH_32 = 32'(STACK_DEPTH);
	localparam logic [33:0]   DEPTH_34 = 34'(STACK_DEPTH);

	function automatic logic [31:0] jt(input logic [31:0] t, input logic [31:0] len);
		jt = (t[31] || t >= len) ? len : t;
	endfunction

	function automatic logic in_stk(input logic [31:0] d);
		in_stk = !d[31] && (d < DEPTH_32);
	endfunction

	pl0_pkg::bst_t   state_q, state_d;
	pl0_pkg::entry_t ent_q;
	logic [9:0]      plen_q;
	logic [31:0]     len_w;
	logic            halted_q;
	logic [PCW-1:0]  pc_q;
	logic [31:0]     pc_w, pc_inc_w;
	logic [SW-1:0]   sp_q, sp_d, bp_q, bp_d;
	logic [SW-1:0]   walk_b_q, walk_b_d, link_q, link_d;
	logic [3:0]      walk_n_q, walk_n_d;
	logic [1:0]      cal_k_q, cal_k_d;

	logic [31:0]     rf [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;
	logic [31:0]     rd0_q, rd1_q;
	logic            rd_en;
	logic            rf_we;
	logic [RW-1:0]   rf_wa;
	logic [31:0]     rf_wd;

	logic [31:0]     mem [STACK_DEPTH];
	logic [31:0]     mem_rd_q;
	logic            rd_zero_q;
	logic [2:0]      init_q;
	logic            mem_we, mem_re;
	logic [SW-1:0]   mem_wa, mem_ra;
	logic [31:0]     mem_wd, mem_dat;

	logic            fin;
	logic [2:0]      fin_st;
	logic [31:0]     fin_npc;
	logic            fin_wv;
	logic [31:0]     fin_wd;
	logic            fin_err;

	logic            out_valid_q;
	logic [2:0]      out_st_q;
	logic [31:0]     out_pc_q;
	logic            out_wv_q;
	logic [31:0]     out_wd_q;
	logic [31:0]     out_sp_q, out_bp_q;

	logic            div_start, div_done;
	logic [31:0]     div_quo, div_rem;
	logic [31:0]     alu_res;
	logic [33:0]     acc_x, inc_x;
	logic            acc_ok, inc_ok, walk_ok, cal_ok, bp3_ok;

	// Effective program length
	assign len_w    = ({22'd0, plen_q} < 32'(CODE_DEPTH)) ? {22'd0, plen_q} : 32'(CODE_DEPTH);
	assign pc_w     = 32'(pc_q);
	assign pc_inc_w = pc_w + 32'd1;
	assign mem_dat  = rd_zero_q ? 32'd0 : mem_rd_q;

	// Address checks
	assign acc_x   = {{(34 - SW){1'b0}}, walk_b_q} + {{2{ent_q.m[31]}}, ent_q.m};
	assign inc_x   = {{(34 - SW){1'b0}}, sp_q} + {{2{ent_q.m[31]}}, ent_q.m};
	assign acc_ok  = !acc_x[33] && (acc_x < DEPTH_34);
	assign inc_ok  = !inc_x[33] && (inc_x < DEPTH_34);
	assign walk_ok = ({1'b0, walk_b_q} + (SW + 1)'(1)) < DEPTH_W;
	assign cal_ok  = ({1'b0, sp_q} + (SW + 1)'(4)) < DEPTH_W;
	assign bp3_ok  = ({1'b0, bp_q} + (SW + 1)'(3)) < DEPTH_W;

	// Register-to-register operations
	always_comb begin
		unique case (ent_q.op)
			pl0_pkg::OP_NEG: alu_res = 32'd0 - rd0_q;
			pl0_pkg::OP_ADD: alu_res = rd0_q + rd1_q;
			pl0_pkg::OP_SUB: alu_res = rd0_q - rd1_q;
			pl0_pkg::OP_MUL: alu_res = rd0_q * rd1_q;
			pl0_pkg::OP_EQL: alu_res = {31'd0, rd0_q == rd1_q};
			pl0_pkg::OP_NEQ: alu_res = {31'd0, rd0_q != rd1_q};
			pl0_pkg::OP_LES: alu_res = {31'd0, $signed(rd0_q) <  $signed(rd1_q)};
			pl0_pkg::OP_LEQ: alu_res = {31'd0, $signed(rd0_q) <= $signed(rd1_q)};
			pl0_pkg::OP_GTR: alu_res = {31'd0, $signed(rd0_q) >  $signed(rd1_q)};
			pl0_pkg::OP_GEQ: alu_res = {31'd0, $signed(rd0_q) >= $signed(rd1_q)};
			default:         alu_res = 32'd0;
		endcase
	end

	// Next state and datapath controls
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		rd_en     = 1'b0;
		fin       = 1'b0;
		fin_st    = pl0_pkg::ST_RUN;
		fin_npc   = pc_inc_w;
		fin_wv    = 1'b0;
		fin_wd    = 32'd0;
		sp_d      = sp_q;
		bp_d      = bp_q;
		rf_we     = 1'b0;
		rf_wa     = ent_q.tgt[RW-1:0];
		rf_wd     = 32'd0;
		mem_we    = 1'b0;
		mem_wa    = acc_x[SW-1:0];
		mem_wd    = rd0_q;
		mem_re    = 1'b0;
		mem_ra    = acc_x[SW-1:0];
		walk_b_d  = walk_b_q;
		walk_n_d  = walk_n_q;
		cal_k_d   = cal_k_q;
		link_d    = link_q;
		div_start = 1'b0;
		unique case (state_q)
			pl0_pkg::BS_IDLE: begin
				if (head_vld && !out_valid_q) begin
					pop = 1'b1;
					if (halted_q || pc_w >= len_w) begin
						fin     = 1'b1;
						fin_st  = pl0_pkg::ST_HALT;
						fin_npc = pc_w;
					end else begin
						rd_en   = 1'b1;
						state_d = pl0_pkg::BS_EXEC;
					end
				end
			end
			pl0_pkg::BS_EXEC: begin
				unique case (ent_q.cls)
					pl0_pkg::CL_LIT: begin
						rf_we = 1'b1;
						rf_wd = ent_q.m;
						fin   = 1'b1;
					end
					pl0_pkg::CL_READ: begin
						rf_we = 1'b1;
						rf_wd = ent_q.rv;
						fin   = 1'b1;
					end
					pl0_pkg::CL_ALU: begin
						rf_we = 1'b1;
						rf_wd = alu_res;
						fin   = 1'b1;
					end
					pl0_pkg::CL_ODD: begin
						rf_we = 1'b1;
						rf_wd = {31'd0, rd0_q[0]};
						fin   = 1'b1;
					end
					pl0_pkg::CL_WRITE: begin
						fin_wv = 1'b1;
						fin_wd = rd0_q;
						fin    = 1'b1;
					end
					pl0_pkg::CL_JMP: begin
						fin_npc = jt(ent_q.m, len_w);
						fin     = 1'b1;
					end
					pl0_pkg::CL_JPC: begin
						if (rd0_q == 32'd0) begin
							fin_npc = jt(ent_q.m, len_w);
						end
						fin = 1'b1;
					end
					pl0_pkg::CL_HALT: begin
						fin_st  = pl0_pkg::ST_HALT;
						fin_npc = pc_w;
						fin     = 1'b1;
					end
					pl0_pkg::CL_INC: begin
						if (inc_ok) begin
							sp_d = inc_x[SW-1:0];
						end else begin
							fin_st = pl0_pkg::ST_STACK;
						end
						fin = 1'b1;
					end
					pl0_pkg::CL_DIV: begin
						if (rd1_q == 32'd0) begin
							fin_st = pl0_pkg::ST_DIVZ;
							fin    = 1'b1;
						end else begin
							div_start = 1'b1;
							state_d   = pl0_pkg::BS_DIV;
						end
					end
					pl0_pkg::CL_LOD, pl0_pkg::CL_STO, pl0_pkg::CL_CAL: begin
						if (ent_q.lvl_bad) begin
							fin_st = pl0_pkg::ST_STACK;
							fin    = 1'b1;
						end else begin
							walk_b_d = bp_q;
							walk_n_d = ent_q.lvl;
							state_d  = pl0_pkg::BS_WALK;
						end
					end
					pl0_pkg::CL_RTN: begin
						if (bp_q == '0 || !bp3_ok) begin
							fin_st = pl0_pkg::ST_STACK;
							fin    = 1'b1;
						end else begin
							mem_re  = 1'b1;
							mem_ra  = bp_q + SW'(2);
							state_d = pl0_pkg::BS_RTN_LINK;
						end
					end
					default: begin
						fin_st = pl0_pkg::ST_BADOP;
						fin    = 1'b1;
					end
				endcase
			end
			pl0_pkg::BS_WALK: begin
				if (walk_n_q == 4'd0) begin
					unique case (ent_q.cls)
						pl0_pkg::CL_LOD: begin
							if (acc_ok) begin
								mem_re  = 1'b1;
								state_d = pl0_pkg::BS_LOD_RD;
							end else begin
								fin_st = pl0_pkg::ST_STACK;
								fin    = 1'b1;
							end
						end
						pl0_pkg::CL_STO: begin
							if (acc_ok) begin
								mem_we = 1'b1;
							end else begin
								fin_st = pl0_pkg::ST_STACK;
							end
							fin = 1'b1;
						end
						default: begin
							if (cal_ok) begin
								cal_k_d = 2'd0;
								state_d = pl0_pkg::BS_CAL;
							end else begin
								fin_st = pl0_pkg::ST_STACK;
								fin    = 1'b1;
							end
						end
					endcase
				end else if (walk_ok) begin
					mem_re   = 1'b1;
					mem_ra   = walk_b_q + SW'(1);
					walk_n_d = walk_n_q - 4'd1;
					state_d  = pl0_pkg::BS_WALK_RD;
				end else begin
					fin_st = pl0_pkg::ST_STACK;
					fin    = 1'b1;
				end
			end
			pl0_pkg::BS_WALK_RD: begin
				if (in_stk(mem_dat)) begin
					walk_b_d = mem_dat[SW-1:0];
					state_d  = pl0_pkg::BS_WALK;
				end else begin
					fin_st = pl0_pkg::ST_STACK;
					fin    = 1'b1;
				end
			end
			pl0_pkg::BS_LOD_RD: begin
				rf_we = 1'b1;
				rf_wd = mem_dat;
				fin   = 1'b1;
			end
			pl0_pkg::BS_CAL: begin
				// Push zero, static link, dynamic link, return address
				mem_we  = 1'b1;
				mem_wa  = sp_q + SW'(1) + SW'(cal_k_q);
				cal_k_d = cal_k_q + 2'd1;
				case (cal_k_q)
					2'd0:    mem_wd = 32'd0;
					2'd1:    mem_wd = 32'(walk_b_q);
					2'd2:    mem_wd = 32'(bp_q);
					default: mem_wd = pc_inc_w;
				endcase
				if (cal_k_q == 2'd3) begin
					bp_d    = sp_q + SW'(1);
					fin_npc = jt(ent_q.m, len_w);
					fin     = 1'b1;
				end
			end
			pl0_pkg::BS_RTN_LINK: begin
				if (in_stk(mem_dat)) begin
					link_d  = mem_dat[SW-1:0];
					mem_re  = 1'b1;
					mem_ra  = bp_q + SW'(3);
					state_d = pl0_pkg::BS_RTN_RET;
				end else begin
					fin_st = pl0_pkg::ST_STACK;
					fin    = 1'b1;
				end
			end
			pl0_pkg::BS_RTN_RET: begin
				sp_d = bp_q - SW'(1);
				bp_d = link_q;
				if (mem_dat == 32'd0) begin
					fin_st  = pl0_pkg::ST_HALT;
					fin_npc = 32'd0;
				end else begin
					fin_npc = jt(mem_dat, len_w);
				end
				fin = 1'b1;
			end
			pl0_pkg::BS_DIV: begin
				if (div_done) begin
					rf_we = 1'b1;
					rf_wd = (ent_q.op == pl0_pkg::OP_DIV) ? div_quo : div_rem;
					fin   = 1'b1;
				end
			end
			default: state_d = pl0_pkg::BS_IDLE;
		endcase
		if (fin) begin
			state_d = pl0_pkg::BS_IDLE;
		end
	end

	assign fin_err = (fin_st == pl0_pkg::ST_DIVZ) || (fin_st == pl0_pkg::ST_BADOP) ||
		(fin_st == pl0_pkg::ST_STACK);

	pl0_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rd0_q),
		.divisor   (rd1_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Stack memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q  <= mem[mem_ra];
			rd_zero_q <= ((mem_ra == SW'(1)) && !init_q[0]) ||
				((mem_ra == SW'(2)) && !init_q[1]) ||
				((mem_ra == SW'(3)) && !init_q[2]);
		end
	end

	// Register file, registered reads
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf[rf_wa] <= rf_wd;
		end
		if (rd_en) begin
			rd0_q <= rf_vld_q[head.rsel0[RW-1:0]] ? rf[head.rsel0[RW-1:0]] : 32'd0;
			rd1_q <= rf_vld_q[head.src_b[RW-1:0]] ? rf[head.src_b[RW-1:0]] : 32'd0;
		end
	end

	// Hold instruction and walk payload
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
		walk_b_q <= walk_b_d;
		walk_n_q <= walk_n_d;
		cal_k_q  <= cal_k_d;
		link_q   <= link_d;
		if (fin) begin
			out_st_q <= (fin_st == pl0_pkg::ST_RUN && fin_npc >= len_w) ?
				pl0_pkg::ST_HALT : fin_st;
			out_pc_q <= fin_err ? pc_w : fin_npc;
			out_wv_q <= fin_wv;
			out_wd_q <= fin_wd;
			out_sp_q <= 32'(sp_d);
			out_bp_q <= 32'(bp_d);
		end
	end

	// Machine state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pl0_pkg::BS_IDLE;
			plen_q      <= 10'd0;
			halted_q    <= 1'b0;
			pc_q        <= '0;
			sp_q        <= '0;
			bp_q        <= SW'(1);
			rf_vld_q    <= '0;
			init_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				plen_q <= cfg_len;
			end
			sp_q <= sp_d;
			bp_q <= bp_d;
			if (rf_we) begin
				rf_vld_q[rf_wa] <= 1'b1;
			end
			if (mem_we) begin
				if (mem_wa == SW'(1)) init_q[0] <= 1'b1;
				if (mem_wa == SW'(2)) init_q[1] <= 1'b1;
				if (mem_wa == SW'(3)) init_q[2] <= 1'b1;
			end
			if (fin) begin
				if (fin_err) begin
					halted_q <= 1'b1;
				end else begin
					pc_q <= fin_npc[PCW-1:0];
					if (fin_st != pl0_pkg::ST_RUN || fin_npc >= len_w) begin
						halted_q <= 1'b1;
					end
				end
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign next_pc     = out_pc_q[8:0];
	assign write_valid = out_wv_q;
	assign write_value = out_wd_q;
	assign stack_top   = out_sp_q[10:0];
	assign frame_base  = out_bp_q[10:0];

endmodule
`default_nettype wire

### rtl/core/pl0_register_machine_execute.sv
`default_nettype none
// Channel  | Signals                                   | Transaction when
// ---------+-------------------------------------------+-------------------------
// input    | in_valid, in_stall, op .. read_value      | in_valid && !in_stall
// output   | out_valid, out_stall, status .. frame_base| out_valid && !out_stall
// config   | cfg_valid, cfg_ready, program_length      | cfg_valid && cfg_ready
//
// Each instruction: registered operand read, execute, registered result; sto,
// lod and cal first walk static links, lod reads the stack, cal pushes a frame,
// rtn reads its links, div/mod waits on the bit-serial divider. A halted
// machine answers from idle. Stack memory has one access per cycle.
// Reset leaves registers 0, sp 0, bp 1, pc 0; no clearing pass is needed.
// A two-entry queue takes input while the executor or a stalled result waits.
module pl0_register_machine_execute #(
	parameter int STACK_DEPTH = 2048,
	parameter int CODE_DEPTH  = 512,
	parameter int LEVELS_MAX  = 3,
	parameter int REG_COUNT   = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [4:0]         op,
	input  wire logic [3:0]         target_reg,
	input  wire logic [3:0]         l_field,
	input  wire logic signed [31:0] m_field,
	input  wire logic signed [31:0] read_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [8:0]              next_pc,
	output logic                    write_valid,
	output logic signed [31:0]      write_value,
	output logic [10:0]             stack_top,
	output logic [10:0]             frame_base,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [9:0]         program_length
);

	pl0_pkg::entry_t head;
	logic            head_vld;
	logic            pop;
	logic [31:0]     wr_val;

	assign cfg_ready = 1'b1;

	pl0_front #(
		.REG_COUNT  (REG_COUNT),
		.LEVELS_MAX (LEVELS_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.target_reg (target_reg),
		.l_field    (l_field),
		.m_field    (m_field),
		.read_value (read_value),
		.head       (head),
		.head_vld   (head_vld),
		.pop        (pop)
	);

	pl0_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.CODE_DEPTH  (CODE_DEPTH),
		.REG_COUNT   (REG_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_len     (program_length),
		.head        (head),
		.head_vld    (head_vld),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.next_pc     (next_pc),
		.write_valid (write_valid),
		.write_value (wr_val),
		.stack_top   (stack_top),
		.frame_base  (frame_base)
	);

	assign write_value = $signed(wr_val);

endmodule
`default_nettype wire

### rtl/core/pl0_checker.sv
`default_nettype none
module pl0_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [8:0]  next_pc,
	input wire logic        write_valid,
	input wire logic [31:0] write_value
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc))
		else $error("stalled result dropped or changed");

	// Status codes stay in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= pl0_pkg::ST_STACK)
		else $error("status out of range");

	// Drop the write value unless a write executed
	a_wzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> write_value == 32'd0)
		else $error("write value without write");

	// A write never comes with an error
	a_werr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |->
			(status == pl0_pkg::ST_RUN || status == pl0_pkg::ST_HALT))
		else $error("write reported with error status");

endmodule

bind pl0_register_machine_execute pl0_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.next_pc     (next_pc),
	.write_valid (write_valid),
	.write_value (write_value)
);
`default_nettype wire
